/* hdl/lattice_gas_node_collision_defines.svh */
// Assertion macros used by the node collision controller.
`ifndef LATTICE_GAS_NODE_COLLISION_DEFINES_SVH
`define LATTICE_GAS_NODE_COLLISION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LGNC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LGNC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lgnc_pkg.sv */
package lgnc_pkg;

    localparam int NUM_DIRS  = 9;
    localparam int DIR_W     = 4;
    localparam int CNT_W     = 16;
    localparam int TOTAL_W   = 20;
    localparam int PICK_W    = 31;
    localparam int TRIAL_W   = 10;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 5;
    localparam int DIV_STEPS = 31;

    localparam logic [DIR_W-1:0]   DIR_LAST     = 4'd8;
    localparam logic [PICK_W-1:0]  SPLIT_RESET  = 31'd268435455;
    localparam logic [TRIAL_W-1:0] TRIALS_RESET = 10'd300;
    localparam logic [TRIAL_W-1:0] TRIAL_MAX    = 10'd1023;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COLLIDE = 2'd1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_SAME  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BIG   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIALS = 1'd1;

    localparam logic [1:0] UPD_DEC_A = 2'd0;
    localparam logic [1:0] UPD_DEC_B = 2'd1;
    localparam logic [1:0] UPD_INC_A = 2'd2;
    localparam logic [1:0] UPD_INC_B = 2'd3;

    typedef enum logic [1:0] {
        RD_WALK = 2'd0,
        RD_UPD  = 2'd1,
        RD_DIR  = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic             capture;
        logic             load_wr;
        logic             clr_trials;
        logic             inc_trials;
        logic             sum_step;
        logic             div_step;
        logic             div_save_a;
        logic             walk_init;
        logic             walk_step;
        logic             rule_calc;
        logic             upd_step;
        logic [1:0]       upd_sel;
        logic             out_load;
        logic [DIR_W-1:0] idx;
        rd_src_t          rd_src;
        logic [1:0]       st;
    } cmd_t;

    typedef struct packed {
        logic total_zero;
        logic total_big;
        logic rem_equal;
    } stat_t;

    // Component code 0, 1, 2 stands for velocity -1, 0, +1.
    function automatic logic [1:0] dir_x(input logic [DIR_W-1:0] d);
        logic [1:0] c;
        case (d)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] dir_y(input logic [DIR_W-1:0] d);
        logic [1:0] c;
        case (d)
            4'd0, 4'd1, 4'd2: c = 2'd0;
            4'd3, 4'd4, 4'd5: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [DIR_W-1:0] make_dir(input logic [1:0] x, input logic [1:0] y);
        return {2'b00, y} + {1'b0, y, 1'b0} + {2'b00, x};
    endfunction

    // Returns {new a, new b} for one axis.
    function automatic logic [3:0] axis_rule(
        input logic [1:0]        a,
        input logic [1:0]        b,
        input logic [PICK_W-1:0] coin,
        input logic [PICK_W-1:0] thr
    );
        logic [3:0] r;
        if ((a == 2'd0 && b == 2'd2) || (a == 2'd2 && b == 2'd0))
        begin
            r = {2'd1, 2'd1};
        end
        else if (a == 2'd1 && b == 2'd1)
        begin
            if (coin < thr)
            begin
                r = (coin < (thr >> 1)) ? {2'd0, 2'd2} : {2'd2, 2'd0};
            end
            else
            begin
                r = {2'd1, 2'd1};
            end
        end
        else
        begin
            r = {b, a};
        end
        return r;
    endfunction

endpackage

/* hdl/lgnc_ctrl.sv */
`include "lattice_gas_node_collision_defines.svh"

module lgnc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           op,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  lgnc_pkg::stat_t      stat,
    output lgnc_pkg::cmd_t       cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SUM   = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_DIV_A = 10'b0000001000,
        S_DIV_B = 10'b0000010000,
        S_CMP   = 10'b0000100000,
        S_WALK  = 10'b0001000000,
        S_RULE  = 10'b0010000000,
        S_UPD   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [lgnc_pkg::STEP_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]                       st_reg, st_next;
    logic                             rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        st_next     = st_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.idx     = cnt_reg[lgnc_pkg::DIR_W-1:0];
        cmd.upd_sel = cnt_reg[1:0];
        cmd.rd_src  = lgnc_pkg::RD_WALK;
        cmd.st      = st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    st_next     = lgnc_pkg::ST_DONE;
                    if (op == lgnc_pkg::OP_COLLIDE)
                    begin
                        cmd.inc_trials = 1'b1;
                        state_next     = S_SUM;
                    end
                    else
                    begin
                        if (op == lgnc_pkg::OP_LOAD)
                        begin
                            cmd.load_wr    = 1'b1;
                            cmd.clr_trials = 1'b1;
                        end
                        state_next = S_FIN;
                    end
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg[lgnc_pkg::DIR_W-1:0] == lgnc_pkg::DIR_LAST)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cnt_next = '0;
                priority if (stat.total_zero)
                begin
                    st_next    = lgnc_pkg::ST_EMPTY;
                    state_next = S_FIN;
                end
                else if (stat.total_big)
                begin
                    st_next    = lgnc_pkg::ST_BIG;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DIV_A;
                end
            end
            S_DIV_A:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST)
                begin
                    // keep the first remainder, reload the divider with the second pick
                    cmd.div_save_a = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_DIV_B;
                end
            end
            S_DIV_B:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cnt_next = '0;
                if (stat.rem_equal)
                begin
                    st_next    = lgnc_pkg::ST_SAME;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg[lgnc_pkg::DIR_W-1:0] == lgnc_pkg::DIR_LAST)
                begin
                    state_next = S_RULE;
                end
            end
            S_RULE:
            begin
                cmd.rule_calc = 1'b1;
                cnt_next      = '0;
                state_next    = S_UPD;
            end
            S_UPD:
            begin
                cmd.rd_src   = lgnc_pkg::RD_UPD;
                cmd.upd_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == lgnc_pkg::UPD_INC_B)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.rd_src = lgnc_pkg::RD_DIR;
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    localparam logic [lgnc_pkg::STEP_W-1:0] STEP_LAST = lgnc_pkg::STEP_W'(lgnc_pkg::DIV_STEPS - 1);

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            st_reg        <= lgnc_pkg::ST_DONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            st_reg        <= st_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `LGNC_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_reg != S_IDLE, "accepted request left controller idle")
    `LGNC_ASSERT_NEXT(a_result_ends_item, cmd.out_load, state_reg == S_IDLE && rsp_valid_reg, "result load did not finish the item")
    `LGNC_ASSERT_SAME(a_div_count, state_reg == S_DIV_A || state_reg == S_DIV_B, cnt_reg < lgnc_pkg::STEP_W'(lgnc_pkg::DIV_STEPS), "divider step count overran")
    `LGNC_ASSERT_SAME(a_no_overwrite, cmd.out_load, !rsp_valid_reg || rsp_ready, "result register overwritten before taken")

endmodule

/* hdl/lgnc_dpath.sv */
module lgnc_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lgnc_pkg::cmd_t                    cmd,
    output lgnc_pkg::stat_t                   stat,
    input  logic [lgnc_pkg::DIR_W-1:0]        dir,
    input  logic [lgnc_pkg::CNT_W-1:0]        count_in,
    input  logic [lgnc_pkg::PICK_W-1:0]       pick_a,
    input  logic [lgnc_pkg::PICK_W-1:0]       pick_b,
    input  logic [lgnc_pkg::PICK_W-1:0]       coin_x,
    input  logic [lgnc_pkg::PICK_W-1:0]       coin_y,
    input  logic                              cfg_we,
    input  logic [lgnc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lgnc_pkg::CFG_W-1:0]        cfg_data,
    output logic [lgnc_pkg::CNT_W-1:0]        count_out,
    output logic [1:0]                        status,
    output logic [lgnc_pkg::DIR_W-1:0]        first_new_dir,
    output logic [lgnc_pkg::DIR_W-1:0]        second_new_dir,
    output logic                              node_done
);

    logic [lgnc_pkg::CNT_W-1:0]   counts_reg [lgnc_pkg::NUM_DIRS];
    logic [lgnc_pkg::TRIAL_W-1:0] trial_reg;
    logic [lgnc_pkg::PICK_W-1:0]  split_reg;
    logic [lgnc_pkg::TRIAL_W-1:0] trials_cfg_reg;

    logic [lgnc_pkg::DIR_W-1:0]   dir_reg;
    logic [lgnc_pkg::PICK_W-1:0]  pb_reg;
    logic [lgnc_pkg::PICK_W-1:0]  cx_reg;
    logic [lgnc_pkg::PICK_W-1:0]  cy_reg;
    logic [lgnc_pkg::TOTAL_W-1:0] total_reg;
    logic [lgnc_pkg::PICK_W-1:0]  dvd_reg;
    logic [lgnc_pkg::CNT_W-1:0]   rem_reg;
    logic [lgnc_pkg::CNT_W-1:0]   r1_reg;
    logic [lgnc_pkg::CNT_W-1:0]   i1_reg;
    logic [lgnc_pkg::CNT_W-1:0]   i2_reg;
    logic                         f1_reg;
    logic                         f2_reg;
    logic [lgnc_pkg::DIR_W-1:0]   d1_reg;
    logic [lgnc_pkg::DIR_W-1:0]   d2_reg;
    logic [lgnc_pkg::DIR_W-1:0]   nd1_reg;
    logic [lgnc_pkg::DIR_W-1:0]   nd2_reg;

    logic [lgnc_pkg::CNT_W-1:0]   count_out_reg;
    logic [1:0]                   status_reg;
    logic [lgnc_pkg::DIR_W-1:0]   first_reg;
    logic [lgnc_pkg::DIR_W-1:0]   second_reg;
    logic                         done_reg;

    logic [lgnc_pkg::DIR_W-1:0]   upd_addr;
    logic [lgnc_pkg::DIR_W-1:0]   rd_addr;
    logic [lgnc_pkg::CNT_W-1:0]   rd_data;
    logic [lgnc_pkg::CNT_W-1:0]   upd_val;
    logic [lgnc_pkg::CNT_W:0]     rem_sh;
    logic [lgnc_pkg::CNT_W:0]     div_ext;
    logic [lgnc_pkg::CNT_W-1:0]   rem_step;
    logic [3:0]                   rule_x;
    logic [3:0]                   rule_y;
    logic                         last_dir;

    // single read port shared by the sum, walk, update and result read
    always_comb
    begin
        unique case (cmd.upd_sel)
            lgnc_pkg::UPD_DEC_A: upd_addr = d1_reg;
            lgnc_pkg::UPD_DEC_B: upd_addr = d2_reg;
            lgnc_pkg::UPD_INC_A: upd_addr = nd1_reg;
            lgnc_pkg::UPD_INC_B: upd_addr = nd2_reg;
            default:             upd_addr = d1_reg;
        endcase
        unique case (cmd.rd_src)
            lgnc_pkg::RD_WALK: rd_addr = cmd.idx;
            lgnc_pkg::RD_UPD:  rd_addr = upd_addr;
            lgnc_pkg::RD_DIR:  rd_addr = dir_reg;
            default:           rd_addr = dir_reg;
        endcase
        rd_data = (rd_addr <= lgnc_pkg::DIR_LAST) ? counts_reg[rd_addr] : '0;
        upd_val = cmd.upd_sel[1] ? rd_data + 1'b1 : rd_data - 1'b1;
    end

    // one restoring step of the remainder
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[lgnc_pkg::PICK_W-1]};
        div_ext  = {1'b0, total_reg[lgnc_pkg::CNT_W-1:0]};
        rem_step = (rem_sh >= div_ext) ? lgnc_pkg::CNT_W'(rem_sh - div_ext)
                                       : rem_sh[lgnc_pkg::CNT_W-1:0];
    end

    assign rule_x   = lgnc_pkg::axis_rule(lgnc_pkg::dir_x(d1_reg), lgnc_pkg::dir_x(d2_reg),
                                          cx_reg, split_reg);
    assign rule_y   = lgnc_pkg::axis_rule(lgnc_pkg::dir_y(d1_reg), lgnc_pkg::dir_y(d2_reg),
                                          cy_reg, split_reg);
    assign last_dir = (cmd.idx == lgnc_pkg::DIR_LAST);

    assign stat.total_zero = (total_reg == '0);
    assign stat.total_big  = (total_reg[lgnc_pkg::TOTAL_W-1:lgnc_pkg::CNT_W] != '0);
    assign stat.rem_equal  = (r1_reg == rem_reg);

    // control state: counts, trial counter and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lgnc_pkg::NUM_DIRS; i++)
            begin
                counts_reg[i] <= '0;
            end
            trial_reg      <= '0;
            split_reg      <= lgnc_pkg::SPLIT_RESET;
            trials_cfg_reg <= lgnc_pkg::TRIALS_RESET;
        end
        else
        begin
            priority if (cmd.load_wr)
            begin
                if (dir <= lgnc_pkg::DIR_LAST)
                begin
                    counts_reg[dir] <= count_in;
                end
            end
            else if (cmd.upd_step)
            begin
                counts_reg[upd_addr] <= upd_val;
            end

            priority if (cmd.clr_trials)
            begin
                trial_reg <= '0;
            end
            else if (cmd.inc_trials && trial_reg != lgnc_pkg::TRIAL_MAX)
            begin
                trial_reg <= trial_reg + 1'b1;
            end

            if (cfg_we)
            begin
                if (cfg_index == lgnc_pkg::CFG_SPLIT)
                begin
                    split_reg <= cfg_data;
                end
                else if (cfg_index == lgnc_pkg::CFG_TRIALS)
                begin
                    trials_cfg_reg <= cfg_data[lgnc_pkg::TRIAL_W-1:0];
                end
            end
        end
    end

    // working registers of one request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dir_reg   <= dir;
            pb_reg    <= pick_b;
            cx_reg    <= coin_x;
            cy_reg    <= coin_y;
            dvd_reg   <= pick_a;
            rem_reg   <= '0;
            total_reg <= '0;
            nd1_reg   <= '0;
            nd2_reg   <= '0;
        end
        if (cmd.sum_step)
        begin
            total_reg <= total_reg + lgnc_pkg::TOTAL_W'(rd_data);
        end
        if (cmd.div_step)
        begin
            if (cmd.div_save_a)
            begin
                r1_reg  <= rem_step;
                rem_reg <= '0;
                dvd_reg <= pb_reg;
            end
            else
            begin
                rem_reg <= rem_step;
                dvd_reg <= dvd_reg << 1;
            end
        end
        if (cmd.walk_init)
        begin
            i1_reg <= r1_reg;
            i2_reg <= rem_reg;
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        if (cmd.walk_step)
        begin
            if (!f1_reg)
            begin
                if (last_dir || i1_reg < rd_data)
                begin
                    f1_reg <= 1'b1;
                    d1_reg <= cmd.idx;
                end
                else
                begin
                    i1_reg <= i1_reg - rd_data;
                end
            end
            if (!f2_reg)
            begin
                if (last_dir || i2_reg < rd_data)
                begin
                    f2_reg <= 1'b1;
                    d2_reg <= cmd.idx;
                end
                else
                begin
                    i2_reg <= i2_reg - rd_data;
                end
            end
        end
        if (cmd.rule_calc)
        begin
            nd1_reg <= lgnc_pkg::make_dir(rule_x[3:2], rule_y[3:2]);
            nd2_reg <= lgnc_pkg::make_dir(rule_x[1:0], rule_y[1:0]);
        end
        if (cmd.out_load)
        begin
            count_out_reg <= rd_data;
            status_reg    <= cmd.st;
            first_reg     <= nd1_reg;
            second_reg    <= nd2_reg;
            done_reg      <= (trial_reg >= trials_cfg_reg);
        end
    end

    assign count_out      = count_out_reg;
    assign status         = status_reg;
    assign first_new_dir  = first_reg;
    assign second_new_dir = second_reg;
    assign node_done      = done_reg;

endmodule

/* hdl/lattice_gas_node_collision.sv */
// Loads and reads go straight to the result. A collision trial sums the counts, checks the
// total, divides both picks in the shared 1-bit-per-cycle remainder unit, walks, applies
// the rule and updates; same-particle picks end at the compare, an empty or oversized node
// at the check. One request at a time; the next is taken the cycle after the result is
// loaded. Reset clears all counts and trial counter, loads configuration reset values.
module lattice_gas_node_collision
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [1:0]                        op,
    input  logic [lgnc_pkg::DIR_W-1:0]        dir,
    input  logic [lgnc_pkg::CNT_W-1:0]        count_in,
    input  logic [lgnc_pkg::PICK_W-1:0]       pick_a,
    input  logic [lgnc_pkg::PICK_W-1:0]       pick_b,
    input  logic [lgnc_pkg::PICK_W-1:0]       coin_x,
    input  logic [lgnc_pkg::PICK_W-1:0]       coin_y,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [lgnc_pkg::CNT_W-1:0]        count_out,
    output logic [1:0]                        status,
    output logic [lgnc_pkg::DIR_W-1:0]        first_new_dir,
    output logic [lgnc_pkg::DIR_W-1:0]        second_new_dir,
    output logic                              node_done,
    input  logic                              cfg_we,
    input  logic [lgnc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lgnc_pkg::CFG_W-1:0]        cfg_data
);

    lgnc_pkg::cmd_t  cmd;
    lgnc_pkg::stat_t stat;

    lgnc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .op        (op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lgnc_dpath u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .dir            (dir),
        .count_in       (count_in),
        .pick_a         (pick_a),
        .pick_b         (pick_b),
        .coin_x         (coin_x),
        .coin_y         (coin_y),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .count_out      (count_out),
        .status         (status),
        .first_new_dir  (first_new_dir),
        .second_new_dir (second_new_dir),
        .node_done      (node_done)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import lgnc_pkg::*;

    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_READ_ALT = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TOTAL_LIMIT = 65535;
    localparam int REPORT_MAX  = 10;
    localparam int unsigned WORD_MAX = 32'h7FFFFFFF;

    typedef struct packed {
        logic [1:0]        op;
        logic [DIR_W-1:0]  dir;
        logic [CNT_W-1:0]  cnt;
        logic [PICK_W-1:0] pick_a;
        logic [PICK_W-1:0] pick_b;
        logic [PICK_W-1:0] coin_x;
        logic [PICK_W-1:0] coin_y;
    } node_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [1:0]       status;
        logic [DIR_W-1:0] first_dir;
        logic [DIR_W-1:0] second_dir;
        logic             done;
    } node_rsp_t;

    typedef struct packed {
        node_req_t req;
        logic      typed;
        node_rsp_t rsp;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    logic [1:0]           op;
    logic [DIR_W-1:0]     dir;
    logic [CNT_W-1:0]     count_in;
    logic [PICK_W-1:0]    pick_a;
    logic [PICK_W-1:0]    pick_b;
    logic [PICK_W-1:0]    coin_x;
    logic [PICK_W-1:0]    coin_y;
    logic                 rsp_valid;
    logic                 rsp_ready;
    logic [CNT_W-1:0]     count_out;
    logic [1:0]           status;
    logic [DIR_W-1:0]     first_new_dir;
    logic [DIR_W-1:0]     second_new_dir;
    logic                 node_done;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // predicted node state and configuration
    logic [CNT_W-1:0] node_cnt [NUM_DIRS];
    int unsigned      trials_seen;
    int unsigned      split_thr;
    int unsigned      trials_cfg;

    node_rsp_t   rsp_due [$];
    stim_row_t   stim_table [$];
    node_rsp_t   got_rsp;
    node_rsp_t   want_rsp;
    int          mismatches;
    int          items_sent;
    int          rsp_seen;
    int          cycles;
    int          status_hits [4];
    int unsigned burst_left;
    int unsigned ready_stretch;

    lattice_gas_node_collision i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .op             (op),
        .dir            (dir),
        .count_in       (count_in),
        .pick_a         (pick_a),
        .pick_b         (pick_b),
        .coin_x         (coin_x),
        .coin_y         (coin_y),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .count_out      (count_out),
        .status         (status),
        .first_new_dir  (first_new_dir),
        .second_new_dir (second_new_dir),
        .node_done      (node_done),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Direction holding particle number idx, walking the counts in order.
    function automatic int locate_dir(input int unsigned idx);
        int          v;
        int unsigned rest;
        v = 0;
        rest = idx;
        while (v < NUM_DIRS - 1 && rest >= node_cnt[v])
        begin
            rest -= node_cnt[v];
            v++;
        end
        return v;
    endfunction

    task automatic resolve_axis(inout int a, inout int b, input int unsigned coin);
        int t;
        if (a * b == -1)
        begin
            a = 0;
            b = 0;
        end
        else if (a == 0 && b == 0)
        begin
            if (coin < split_thr)
            begin
                if (coin < split_thr / 2)
                begin
                    a = -1;
                    b = 1;
                end
                else
                begin
                    a = 1;
                    b = -1;
                end
            end
        end
        else
        begin
            t = a;
            a = b;
            b = t;
        end
    endtask

    task automatic advance_node(input node_req_t r, output node_rsp_t e);
        int unsigned total;
        int unsigned r1;
        int unsigned r2;
        int          v;
        int          d1, d2, ax, ay, bx, by, n1, n2;
        e = '0;
        if (r.op == OP_LOAD)
        begin
            if (r.dir <= DIR_LAST)
                node_cnt[r.dir] = r.cnt;
            trials_seen = 0;
        end
        else if (r.op == OP_COLLIDE)
        begin
            total = 0;
            for (v = 0; v < NUM_DIRS; v++)
                total += node_cnt[v];
            if (trials_seen < TRIAL_MAX)
                trials_seen++;
            if (total == 0)
                e.status = ST_EMPTY;
            else if (total > TOTAL_LIMIT)
                e.status = ST_BIG;
            else
            begin
                r1 = r.pick_a % total;
                r2 = r.pick_b % total;
                if (r1 == r2)
                    e.status = ST_SAME;
                else
                begin
                    d1 = locate_dir(r1);
                    d2 = locate_dir(r2);
                    ax = d1 % 3 - 1;
                    ay = d1 / 3 - 1;
                    bx = d2 % 3 - 1;
                    by = d2 / 3 - 1;
                    resolve_axis(ax, bx, r.coin_x);
                    resolve_axis(ay, by, r.coin_y);
                    n1 = (ay + 1) * 3 + ax + 1;
                    n2 = (by + 1) * 3 + bx + 1;
                    node_cnt[d1] = node_cnt[d1] - 1'b1;
                    node_cnt[d2] = node_cnt[d2] - 1'b1;
                    node_cnt[n1] = node_cnt[n1] + 1'b1;
                    node_cnt[n2] = node_cnt[n2] + 1'b1;
                    e.first_dir = n1[DIR_W-1:0];
                    e.second_dir = n2[DIR_W-1:0];
                end
            end
        end
        e.count = (r.dir <= DIR_LAST) ? node_cnt[r.dir] : '0;
        e.done = (trials_seen >= trials_cfg);
    endtask

    function automatic logic [PICK_W-1:0] rand_word();
        return $urandom;
    endfunction

    // Bias toward small coins, to make splits more likely under small thresholds.
    function automatic logic [PICK_W-1:0] rand_coin();
        logic [PICK_W-1:0] w;
        w = rand_word();
        return ($urandom_range(0, 3) == 0) ? w : w >> $urandom_range(1, 6);
    endfunction

    function automatic node_req_t rand_req();
        node_req_t r;
        r.op = $urandom_range(0, 3);
        r.dir = $urandom_range(0, 15);
        r.cnt = $urandom;
        r.pick_a = rand_word();
        r.pick_b = rand_word();
        r.coin_x = rand_word();
        r.coin_y = rand_word();
        return r;
    endfunction

    task automatic add_row(input logic [1:0] o, input int d, input int c,
                           input int unsigned pa, input int unsigned pb,
                           input int unsigned cx, input int unsigned cy,
                           input bit typed, input int ec, input logic [1:0] es,
                           input bit ed);
        stim_row_t row;
        row.req = '{o, d[DIR_W-1:0], c[CNT_W-1:0], pa[PICK_W-1:0], pb[PICK_W-1:0],
                    cx[PICK_W-1:0], cy[PICK_W-1:0]};
        row.typed = typed;
        row.rsp = '{ec[CNT_W-1:0], es, 4'd0, 4'd0, ed};
        stim_table.push_back(row);
    endtask

    task automatic push_req(input node_req_t r, input bit typed, input node_rsp_t fixed);
        node_rsp_t   pred;
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        op <= r.op;
        dir <= r.dir;
        count_in <= r.cnt;
        pick_a <= r.pick_a;
        pick_b <= r.pick_b;
        coin_x <= r.coin_x;
        coin_y <= r.coin_y;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        advance_node(r, pred);
        rsp_due.push_back(typed ? fixed : pred);
        items_sent++;
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic drain_node();
        @(negedge clk);
        req_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SPLIT)
            split_thr = value & WORD_MAX;
        else
            trials_cfg = value & 32'h3FF;
    endtask

    // Load a whole node, then run trials on it with some reads and, when noise_ok is set, stray loads.
    task automatic run_episode(input int steps, input bit noise_ok);
        int unsigned ceiling;
        int          pick;
        int          kind;
        int          v;
        int          n;
        node_req_t   r;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            ceiling = 0;
        else if (pick < 70)
            ceiling = 12;
        else if (pick < 90)
            ceiling = 400;
        else if (pick < 97)
            ceiling = 7000;
        else
            ceiling = 65535;
        for (v = 0; v < NUM_DIRS; v++)
        begin
            r = rand_req();
            r.op = OP_LOAD;
            r.dir = v;
            r.cnt = $urandom_range(0, ceiling);
            push_req(r, 1'b0, '0);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            r = rand_req();
            r.op = OP_LOAD;
            r.dir = $urandom_range(9, 15);
            push_req(r, 1'b0, '0);
        end
        for (n = 0; n < steps; n++)
        begin
            r = rand_req();
            kind = $urandom_range(0, 99);
            if (kind < 82 || (!noise_ok && kind >= 92))
            begin
                r.op = OP_COLLIDE;
                r.dir = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                    : $urandom_range(0, 8);
                if ($urandom_range(0, 19) == 0)
                    r.pick_b = r.pick_a;
                r.coin_x = rand_coin();
                r.coin_y = rand_coin();
            end
            else if (kind < 92)
            begin
                r.op = $urandom_range(0, 1) ? OP_READ : OP_READ_ALT;
            end
            else
            begin
                r.op = OP_LOAD;
                r.cnt = $urandom_range(0, ceiling);
            end
            push_req(r, 1'b0, '0);
            if ($urandom_range(0, 99) < 2)
                drain_node();
        end
    endtask

    // Receiver stalls on its own pattern, with long stretches of steady ready.
    initial
    begin
        rsp_ready = 1'b0;
        ready_stretch = 0;
        forever
        begin
            @(negedge clk);
            if (ready_stretch == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    rsp_ready <= 1'b0;
                    ready_stretch = $urandom_range(1, 12);
                end
                else
                begin
                    rsp_ready <= 1'b1;
                    ready_stretch = ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(1, 40);
                end
            end
            ready_stretch--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got_rsp = {count_out, status, first_new_dir, second_new_dir, node_done};
            rsp_seen++;
            status_hits[status]++;
            if (rsp_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with no request pending: count %0d status %0d",
                             $time, count_out, status);
            end
            else
            begin
                want_rsp = rsp_due.pop_front();
                if (got_rsp.count !== want_rsp.count || got_rsp.status !== want_rsp.status
                    || got_rsp.first_dir !== want_rsp.first_dir
                    || got_rsp.second_dir !== want_rsp.second_dir
                    || got_rsp.done !== want_rsp.done)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"%0t: mismatch exp count %0d st %0d dirs %0d/%0d done %0d,",
                                  " got count %0d st %0d dirs %0d/%0d done %0d"},
                                 $time, want_rsp.count, want_rsp.status, want_rsp.first_dir,
                                 want_rsp.second_dir, want_rsp.done, got_rsp.count,
                                 got_rsp.status, got_rsp.first_dir, got_rsp.second_dir,
                                 got_rsp.done);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, rsp_due.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        op = OP_LOAD;
        dir = '0;
        count_in = '0;
        pick_a = '0;
        pick_b = '0;
        coin_x = '0;
        coin_y = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SPLIT;
        cfg_data = '0;
        for (int v = 0; v < NUM_DIRS; v++)
            node_cnt[v] = '0;
        for (int s = 0; s < 4; s++)
            status_hits[s] = 0;
        trials_seen = 0;
        split_thr = SPLIT_RESET;
        trials_cfg = TRIALS_RESET;
        mismatches = 0;
        items_sent = 0;
        rsp_seen = 0;
        burst_left = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // op, dir, count, pick_a, pick_b, coin_x, coin_y, typed, count, status, done
        add_row(OP_READ,     0, 0,        0, 0, 0, 0, 1, 0, ST_DONE, 0);
        add_row(OP_COLLIDE,  0, 0,        0, 0, 0, 0, 1, 0, ST_EMPTY, 0);
        add_row(OP_READ_ALT, 8, 16'hFFFF, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                1, 0, ST_DONE, 0);
        // out-of-range direction: load writes nothing, reads give zero
        add_row(OP_LOAD,    15, 16'hFFFF, 0, 0, 0, 0, 1, 0, ST_DONE, 0);
        add_row(OP_READ,     9, 0,        0, 0, 0, 0, 1, 0, ST_DONE, 0);
        add_row(OP_LOAD,     0, 16'hFFFF, 0, 0, 0, 0, 1, 16'hFFFF, ST_DONE, 0);
        // total exactly at the limit still runs the trial
        add_row(OP_COLLIDE,  0, 0,        WORD_MAX, 0, 0, 0, 0, 0, ST_DONE, 0);
        add_row(OP_LOAD,     8, 16'hFFFF, 0, 0, 0, 0, 1, 16'hFFFF, ST_DONE, 0);
        add_row(OP_COLLIDE,  8, 0,        0, 1, 0, 0, 1, 16'hFFFF, ST_BIG, 0);
        add_row(OP_LOAD,     0, 0,        0, 0, 0, 0, 1, 0, ST_DONE, 0);
        add_row(OP_LOAD,     8, 0,        0, 0, 0, 0, 1, 0, ST_DONE, 0);
        add_row(OP_LOAD,     4, 1,        0, 0, 0, 0, 1, 1, ST_DONE, 0);
        add_row(OP_COLLIDE,  4, 0,        WORD_MAX, 0, 0, 0, 1, 1, ST_SAME, 0);
        add_row(OP_LOAD,     0, 1,        0, 0, 0, 0, 1, 1, ST_DONE, 0);
        add_row(OP_COLLIDE,  0, 0,        0, 1, 0, 0, 0, 0, ST_DONE, 0);
        add_row(OP_LOAD,     2, 1,        0, 0, 0, 0, 1, 1, ST_DONE, 0);
        add_row(OP_COLLIDE,  2, 0,        0, 1, 0, 0, 0, 0, ST_DONE, 0);
        add_row(OP_LOAD,     4, 6,        0, 0, 0, 0, 1, 6, ST_DONE, 0);
        add_row(OP_COLLIDE,  4, 0,        4, 5, 0, 0, 0, 0, ST_DONE, 0);
        add_row(OP_COLLIDE,  4, 0,        32'h55555555, 32'h2AAAAAAA, 268435454, 134217727,
                0, 0, ST_DONE, 0);
        add_row(OP_COLLIDE,  4, 0,        WORD_MAX, WORD_MAX - 1, WORD_MAX, WORD_MAX,
                0, 0, ST_DONE, 0);
        add_row(OP_COLLIDE,  1, 0,        32'h40000000, 32'h3FFFFFFF, 134217728, 268435455,
                0, 0, ST_DONE, 0);
        add_row(OP_READ,     4, 0,        0, 0, 0, 0, 0, 0, ST_DONE, 0);
        add_row(OP_LOAD,     7, 16'h8000, 0, 0, 0, 0, 1, 16'h8000, ST_DONE, 0);
        add_row(OP_COLLIDE,  7, 0,        32'h01234567, 32'h07654321, 0, WORD_MAX,
                0, 0, ST_DONE, 0);

        foreach (stim_table[i])
            push_req(stim_table[i].req, stim_table[i].typed, stim_table[i].rsp);
        drain_node();

        repeat (4) run_episode(20, 1'b1);
        drain_node();
        write_reg(CFG_SPLIT, 0);
        write_reg(CFG_TRIALS, 0);
        repeat (4) run_episode(20, 1'b1);

        // one long run without stray loads drives the trial counter into saturation
        drain_node();
        write_reg(CFG_SPLIT, WORD_MAX);
        write_reg(CFG_TRIALS, TRIAL_MAX);
        run_episode(1200, 1'b0);

        drain_node();
        write_reg(CFG_SPLIT, $urandom_range(0, WORD_MAX));
        write_reg(CFG_TRIALS, $urandom_range(1, 40));
        repeat (4) run_episode(20, 1'b1);
        drain_node();
        write_reg(CFG_SPLIT, 1);
        write_reg(CFG_TRIALS, 1);
        repeat (3) run_episode(20, 1'b1);
        drain_node();
        write_reg(CFG_SPLIT, $urandom_range(0, WORD_MAX));
        write_reg(CFG_TRIALS, $urandom_range(0, 1023));
        repeat (3) run_episode(25, 1'b1);

        drain_node();
        repeat (100) @(posedge clk);
        if (rsp_due.size() != 0)
        begin
            mismatches++;
            $display("%0d predicted results never arrived", rsp_due.size());
        end
        $display("%0d requests over six register settings, %0d results checked, %0d mismatches",
                 items_sent, rsp_seen, mismatches);
        $display("status codes seen: done %0d, same particle %0d, empty node %0d, too large %0d",
                 status_hits[ST_DONE], status_hits[ST_SAME], status_hits[ST_EMPTY],
                 status_hits[ST_BIG]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lgnc_pkg.sv
hdl/lgnc_ctrl.sv
hdl/lgnc_dpath.sv
hdl/lattice_gas_node_collision.sv
bench/testbench.sv
